/* hw/rtl/fsia_pkg.sv */
`default_nettype none

package fsia_pkg;

    // Fixed field widths of the block's ports and internal results
    localparam int KEY_W   = 64;
    localparam int BASE_W  = 16;
    localparam int ID_W    = 17;
    localparam int ORDER_W = 16;

    // One accepted transaction as it waits between the front and back parts
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             sol;
    } fsia_item_t;

    // Lookup outcome handed from the back part to the output stage
    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic               was_new;
        logic               full;
    } fsia_result_t;

endpackage

`default_nettype wire

/* hw/rtl/fsia_queue.sv */
`default_nettype none

module fsia_queue
    import fsia_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire fsia_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output fsia_item_t      pop_item
);

    fsia_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold the transaction payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

endmodule

`default_nettype wire

/* hw/rtl/fsia_scan.sv */
`default_nettype none

module fsia_scan
    import fsia_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire fsia_item_t item,
    output logic            item_pop,
    output logic            res_valid,
    output fsia_result_t    res
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic [KEY_BITS-1:0] key_mem [CAPACITY];
    logic [KEY_BITS-1:0] rd_data_reg;

    logic                state_reg;
    logic                state_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    addr_next;
    logic                cmp_v_reg;
    logic                cmp_v_next;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [IDX_W-1:0]    cmp_idx_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    fsia_result_t        res_reg;
    fsia_result_t        res_next;

    logic                rd_en;
    logic                wr_en;
    logic                hit;

    assign hit       = cmp_v_reg && (rd_data_reg == key_reg);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Walk the filled entries in order; compare one entry a cycle
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        cmp_v_next     = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        item_pop       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop   = 1'b1;
                    key_next   = item.key[KEY_BITS-1:0];
                    addr_next  = '0;
                    state_next = ST_SCAN;
                    if (item.sol)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.order   = ORDER_W'(cmp_idx_reg);
                    res_next.was_new = 1'b0;
                    res_next.full    = 1'b0;
                    res_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
                else if (addr_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = addr_reg[IDX_W-1:0];
                    addr_next    = addr_reg + CNT_W'(1);
                end
                else if (!cmp_v_reg)
                begin
                    // Miss: enter the key unless the store is full
                    res_next.was_new = 1'b1;
                    res_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        res_next.order = '0;
                        res_next.full  = 1'b1;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        res_next.order = ORDER_W'(count_reg);
                        res_next.full  = 1'b0;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            cmp_v_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            cmp_v_reg     <= cmp_v_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    // Key store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[count_reg[IDX_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[addr_reg[IDX_W-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (addr_reg <= count_reg))
        else $error("scan address past filled entries");

    a_full_is_new: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.full) |-> (res_reg.was_new && $past(count_reg) ==
        CNT_W'(CAPACITY)))
        else $error("full flagged while entries remain");

    a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (state_reg == ST_IDLE && !cmp_v_reg))
        else $error("result issued while lookup in flight");

endmodule

`default_nettype wire

/* hw/rtl/first_seen_id_assigner.sv */
// The back part handles one transaction at a time and walks the key store's single
// read port one entry a cycle, so its time per transaction grows with n, the number
// of entries filled in the current list; a hit at entry i ends the walk there and
// gives the result.
// A two-entry queue takes new transactions while a lookup runs; done cannot stall.
// Reset empties the store and queue and clears id_base to zero.
`default_nettype none

module first_seen_id_assigner
    import fsia_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [BASE_W-1:0] cfg_wdata,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [KEY_W-1:0]  key_value,
    input  wire logic              start_of_list,
    output logic                   done,
    output logic [ID_W-1:0]        assigned_id,
    output logic                   was_new,
    output logic                   table_full
);

    logic [BASE_W-1:0] id_base_reg;
    logic              done_reg;
    logic [ID_W-1:0]   id_out_reg;
    logic              was_new_reg;
    logic              full_reg;
    logic [ID_W-1:0]   id_next;

    fsia_item_t        push_item;
    fsia_item_t        pop_item;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic              res_valid;
    fsia_result_t      res;

    assign push_item.key = key_value;
    assign push_item.sol = start_of_list;
    assign busy          = q_full;

    fsia_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !q_full),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    fsia_scan #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (pop_item),
        .item_pop   (q_pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Add the current base to the stored order; a key refused by a full store gets zero
    always_comb
    begin
        if (res.full)
        begin
            id_next = '0;
        end
        else
        begin
            id_next = ID_W'(id_base_reg) + ID_W'(res.order);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_base_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
            if (cfg_we)
            begin
                id_base_reg <= cfg_wdata;
            end
        end
    end

    // Capture the result with the done strobe; it holds until the next result
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            id_out_reg  <= id_next;
            was_new_reg <= res.was_new;
            full_reg    <= res.full;
        end
    end

    assign done        = done_reg;
    assign assigned_id = id_out_reg;
    assign was_new     = was_new_reg;
    assign table_full  = full_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fsia_pkg::*;

    localparam int STORE_DEPTH    = 1024;
    localparam int KEY_USED       = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = STORE_DEPTH + 64;

    // Expected outcome of one lookup, laid out as the result ports
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            was_new;
        logic            full;
    } id_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic [BASE_W-1:0] cfg_wdata     = '0;
    logic              start         = 1'b0;
    logic [KEY_W-1:0]  key_value     = '0;
    logic              start_of_list = 1'b0;
    logic              busy;
    logic              done;
    logic [ID_W-1:0]   assigned_id;
    logic              was_new;
    logic              table_full;

    // Pending keys, expected identifiers and the predictor's own state
    fsia_item_t        pending_keys[$];
    id_result_t        exp_ids[$];
    int                seen_order[bit [KEY_W-1:0]];
    logic [BASE_W-1:0] model_base = '0;
    logic [KEY_W-1:0]  list_keys[$];

    int issued      = 0;
    int accepted    = 0;
    int fail_count  = 0;
    int quiet_count = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    bit drain_hold  = 1'b0;

    first_seen_id_assigner #(
        .CAPACITY(STORE_DEPTH),
        .KEY_BITS(KEY_USED)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .key_value    (key_value),
        .start_of_list(start_of_list),
        .done         (done),
        .assigned_id  (assigned_id),
        .was_new      (was_new),
        .table_full   (table_full)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Look a key up in the list, entering it in order of first appearance
    function automatic id_result_t lookup_key(input logic [KEY_W-1:0] key, input logic sol);
        id_result_t r;
        int         ord;
        r = '0;
        if (sol)
            seen_order.delete();
        if (seen_order.exists(key)) begin
            ord  = seen_order[key];
            r.id = ID_W'(model_base) + ID_W'(ord);
        end else begin
            r.was_new = 1'b1;
            if (seen_order.num() >= STORE_DEPTH) begin
                r.full = 1'b1;
            end else begin
                ord             = seen_order.num();
                seen_order[key] = ord;
                r.id            = ID_W'(model_base) + ID_W'(ord);
            end
        end
        return r;
    endfunction

    task automatic queue_key(input logic [KEY_W-1:0] key, input logic sol);
        fsia_item_t item;
        item.key = key;
        item.sol = sol;
        pending_keys.push_back(item);
    endtask

    // Wait until every transaction is taken, answered and the block is free
    task automatic wait_idle;
        @(negedge clk);
        while (pending_keys.size() != 0 || accepted != issued || exp_ids.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= BASE_W'($urandom);
    endtask

    // Mostly repeats and near misses within short lists, some fresh lists
    task automatic queue_random_keys(input int count);
        logic [KEY_W-1:0] k;
        logic             sol;
        int               pick;
        bit               repeat_key;
        for (int n = 0; n < count; n++) begin
            sol        = 1'b0;
            repeat_key = 1'b0;
            if (list_keys.size() == 0 || list_keys.size() >= 40 || $urandom_range(0, 29) == 0) begin
                sol = 1'b1;
                list_keys.delete();
            end
            pick = $urandom_range(0, 99);
            if (pick < 45 && list_keys.size() > 0) begin
                k          = list_keys[$urandom_range(0, list_keys.size() - 1)];
                repeat_key = 1'b1;
            end else if (pick < 55 && list_keys.size() > 0) begin
                k = list_keys[$urandom_range(0, list_keys.size() - 1)];
                k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
            end else if (pick < 65) begin
                k = KEY_W'($urandom_range(0, 15));
            end else if (pick < 70) begin
                k = ~KEY_W'($urandom_range(0, 15));
            end else begin
                k = {$urandom, $urandom};
            end
            if (!repeat_key)
                list_keys.push_back(k);
            queue_key(k, sol);
        end
    endtask

    // Drive transactions in bursts, hold each until it is taken
    always @(negedge clk) begin
        fsia_item_t nxt;
        if (rst_n && !(start && accepted != issued)) begin
            if (burst_left == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if ($urandom_range(0, 9) == 0) begin
                    burst_left = $urandom_range(100, 300);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = $urandom_range(0, 8);
                    drain_hold = ($urandom_range(0, 15) == 0);
                end
            end
            if (drain_hold && exp_ids.size() == 0)
                drain_hold = 1'b0;
            if (burst_left > 0 && !drain_hold && pending_keys.size() > 0) begin
                nxt            = pending_keys.pop_front();
                start         <= 1'b1;
                key_value     <= nxt.key;
                start_of_list <= nxt.sol;
                issued++;
                burst_left--;
            end else begin
                start         <= 1'b0;
                key_value     <= {$urandom, $urandom};
                start_of_list <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Check results against the oldest expectation, record new transactions
    always @(posedge clk) begin
        id_result_t got;
        id_result_t want;
        if (rst_n) begin
            if (done) begin
                got = {assigned_id, was_new, table_full};
                if (exp_ids.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result at %0t: id=%0d new=%0b full=%0b",
                                 $time, got.id, got.was_new, got.full);
                    fail_count++;
                end else begin
                    want = exp_ids.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display("mismatch at %0t: expected id=%0d new=%0b full=%0b, got id=%0d new=%0b full=%0b",
                                     $time, want.id, want.was_new, want.full,
                                     got.id, got.was_new, got.full);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                model_base = cfg_wdata;
            if (start && !busy) begin
                exp_ids.push_back(lookup_key(key_value, start_of_list));
                accepted++;
            end
            // Watchdog on cycles with no transaction either way
            if (done || (start && !busy)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
                if (quiet_count >= WATCHDOG_LIMIT) begin
                    $display("tb failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] fill_keys[$];
        bit               used_key[bit [KEY_W-1:0]];
        logic [KEY_W-1:0] k;
        logic [BASE_W-1:0] phase_base;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, hits, clear before lookup, all under the reset base
        queue_key('0, 1'b0);
        queue_key('1, 1'b0);
        queue_key('0, 1'b0);
        queue_key('1, 1'b0);
        queue_key(64'h8000_0000_0000_0000, 1'b0);
        queue_key(64'h1, 1'b0);
        queue_key(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        queue_key(64'h1, 1'b0);
        queue_key('1, 1'b1);
        queue_key('0, 1'b0);
        queue_key(64'h8000_0000_0000_0000, 1'b0);
        queue_key('0, 1'b0);
        queue_key('0, 1'b1);
        queue_key('0, 1'b1);
        queue_key(64'h5555_5555_5555_5555, 1'b0);
        queue_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

        // Change the base mid-list: stored order rides on the new base
        write_base('1);
        queue_key('0, 1'b0);
        queue_key(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_key(64'h0123_4567_89AB_CDEF, 1'b0);
        queue_key(64'h5555_5555_5555_5555, 1'b0);

        // Random phases over several bases, lists often carried across
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       phase_base = '0;
                1:       phase_base = '1;
                3:       phase_base = 16'h8000;
                default: phase_base = BASE_W'($urandom_range(0, 65535));
            endcase
            write_base(phase_base);
            queue_random_keys(100);
        end

        // Fill the store to capacity with distinct keys
        write_base(BASE_W'($urandom_range(0, 65535)));
        for (int n = 0; n < STORE_DEPTH; n++) begin
            do
                k = {$urandom, $urandom};
            while (used_key.exists(k));
            used_key[k] = 1'b1;
            fill_keys.push_back(k);
            queue_key(k, n == 0);
        end

        // Probe the full store under the top base: widest identifier, refused keys
        write_base('1);
        do
            k = {$urandom, $urandom};
        while (used_key.exists(k));
        queue_key(k, 1'b0);
        queue_key(fill_keys[STORE_DEPTH - 1], 1'b0);
        queue_key(fill_keys[0], 1'b0);
        queue_key(k, 1'b0);
        queue_key(fill_keys[STORE_DEPTH / 2], 1'b0);
        queue_key('1, 1'b0);
        write_base('0);
        queue_key(fill_keys[STORE_DEPTH - 1], 1'b0);
        queue_key(k, 1'b0);
        queue_key(fill_keys[5], 1'b1);
        queue_key(fill_keys[6], 1'b0);
        list_keys.delete();

        write_base(BASE_W'($urandom_range(0, 65535)));
        queue_random_keys(100);

        // Drain, then give the block time to show any stray result
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && exp_ids.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
